### hw/rtl/posit64_to_unsigned_int_defines.svh
// Assertion helpers shared by the converter RTL.
`ifndef POSIT64_TO_UNSIGNED_INT_DEFINES_SVH
`define POSIT64_TO_UNSIGNED_INT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define P64U_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define P64U_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/p64u_pkg.sv
package p64u_pkg;

  localparam logic [63:0] HALF_WORD     = 64'h3800_0000_0000_0000;
  localparam logic [63:0] ONE_HALF_WORD = 64'h4400_0000_0000_0000;
  localparam logic [63:0] TWO_HALF_WORD = 64'h4A00_0000_0000_0000;
  localparam logic [63:0] MAX_FIT_WORD  = 64'h7FFF_BFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  // Regime bits examined after the leading regime one (bits 61 down to 47).
  localparam int unsigned REGIME_SCAN = 15;
  localparam logic [5:0]  FRAC_BITS   = 6'd60;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_TWO,
    KIND_MAX,
    KIND_NORM
  } p64u_kind_e;

  // Stage 1 -> stage 2: classification and regime run length.
  typedef struct packed {
    logic        valid;
    p64u_kind_e  kind;
    logic [3:0]  regime_len;
    logic [61:0] body;
  } s1_t;

  // Stage 2 -> stage 3: scale and significand with hidden bit.
  typedef struct packed {
    logic        valid;
    p64u_kind_e  kind;
    logic [5:0]  scale;
    logic [60:0] sig;
  } s2_t;

endpackage

### hw/rtl/p64u_classify.sv
module p64u_classify (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [63:0]   posit_bits_i,
  output p64u_pkg::s1_t s1_o
);
  import p64u_pkg::*;

  p64u_kind_e kind_d;
  logic [3:0] run_len_d;
  logic       valid_q;
  p64u_kind_e kind_q;
  logic [3:0] run_len_q;
  logic [61:0] body_q;

  always_comb begin
    priority if (posit_bits_i[63]) begin
      kind_d = KIND_ZERO;
    end else if (posit_bits_i <= HALF_WORD) begin
      kind_d = KIND_ZERO;
    end else if (posit_bits_i < ONE_HALF_WORD) begin
      kind_d = KIND_ONE;
    end else if (posit_bits_i <= TWO_HALF_WORD) begin
      kind_d = KIND_TWO;
    end else if (posit_bits_i > MAX_FIT_WORD) begin
      kind_d = KIND_MAX;
    end else begin
      kind_d = KIND_NORM;
    end
  end

  // Leading-ones count below the first regime bit; the first zero wins.
  always_comb begin
    run_len_d = 4'(REGIME_SCAN);
    for (int i = REGIME_SCAN - 1; i >= 0; i--) begin
      if (!posit_bits_i[61 - i]) begin
        run_len_d = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    run_len_q <= run_len_d;
    body_q    <= posit_bits_i[61:0];
  end

  assign s1_o = '{valid: valid_q, kind: kind_q, regime_len: run_len_q, body: body_q};

endmodule

### hw/rtl/p64u_align.sv
`include "posit64_to_unsigned_int_defines.svh"

module p64u_align (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  p64u_pkg::s1_t s1_i,
  output p64u_pkg::s2_t s2_o
);
  import p64u_pkg::*;

  logic [4:0]  shamt;
  logic [61:0] shifted;
  logic [5:0]  scale_d;
  logic        valid_q;
  p64u_kind_e  kind_q;
  logic [5:0]  scale_q;
  logic [60:0] sig_q;

  // Drop the regime run and its terminating bit; exponent lands on top.
  assign shamt   = {1'b0, s1_i.regime_len} + 5'd1;
  assign shifted = s1_i.body << shamt;
  assign scale_d = {s1_i.regime_len, 2'b00} + {4'b0000, shifted[61:60]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= s1_i.kind;
    scale_q <= scale_d;
    sig_q   <= {1'b1, shifted[59:0]};
  end

  assign s2_o = '{valid: valid_q, kind: kind_q, scale: scale_q, sig: sig_q};

  `P64U_ASSERT_NOW(a_norm_scale_nonzero, valid_q && kind_q == KIND_NORM,
    scale_q != 6'd0, "normal-path scale is zero")

endmodule

### hw/rtl/p64u_round.sv
module p64u_round (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  p64u_pkg::s2_t s2_i,
  output logic          valid_o,
  output logic [63:0]   value_o
);
  import p64u_pkg::*;

  logic        left;
  logic [1:0]  lsh;
  logic [5:0]  sh;
  logic [5:0]  sh_m1;
  logic [60:0] res;
  logic [60:0] rnd_vec;
  logic [60:0] lo_mask;
  logic        rnd;
  logic        sticky;
  logic [63:0] mag_d;
  logic        inc_d;

  logic        s3_valid_q;
  p64u_kind_e  s3_kind_q;
  logic [63:0] s3_mag_q;
  logic        s3_inc_q;

  logic [63:0] value_d;
  logic        out_valid_q;
  logic [63:0] out_value_q;

  // Scale above 60 shifts left exactly; otherwise shift right and round.
  assign left    = s2_i.scale > FRAC_BITS;
  assign lsh     = 2'(s2_i.scale - FRAC_BITS);
  assign sh      = FRAC_BITS - s2_i.scale;
  assign sh_m1   = sh - 6'd1;
  assign res     = s2_i.sig >> sh;
  assign rnd_vec = s2_i.sig >> sh_m1;
  assign lo_mask = ~({61{1'b1}} << sh_m1);
  assign rnd     = (sh != 6'd0) && rnd_vec[0];
  assign sticky  = (sh > 6'd1) && ((s2_i.sig & lo_mask) != '0);

  always_comb begin
    if (left) begin
      mag_d = {3'b000, s2_i.sig} << lsh;
      inc_d = 1'b0;
    end else begin
      mag_d = {3'b000, res};
      inc_d = rnd && (res[0] || sticky);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s3_valid_q  <= s2_i.valid;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_kind_q <= s2_i.kind;
    s3_mag_q  <= mag_d;
    s3_inc_q  <= inc_d;
  end

  always_comb begin
    unique case (s3_kind_q)
      KIND_ZERO: value_d = '0;
      KIND_ONE:  value_d = 64'd1;
      KIND_TWO:  value_d = 64'd2;
      KIND_MAX:  value_d = ALL_ONES;
      KIND_NORM: value_d = s3_mag_q + {63'd0, s3_inc_q};
      default:   value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= value_d;
  end

  assign valid_o = out_valid_q;
  assign value_o = out_value_q;

endmodule

### hw/rtl/posit64_to_unsigned_int.sv
// Posit (64-bit, two exponent bits) to unsigned 64-bit integer, round to
// nearest even. Four-stage pipeline: a word given with start appears on
// integer_value_o, marked by a one-cycle valid_o, and a new word may be
// given every cycle. busy stays low, so every start is a transfer. The
// stages are classify/regime count, regime strip, shift/round-bit
// extraction and increment. There is no output hold: the receiver must
// take each result in the cycle valid_o is high.
// Negative words and NaR give 0; words above the largest representable
// integer saturate to all ones.
`include "posit64_to_unsigned_int_defines.svh"

module posit64_to_unsigned_int (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] posit_bits_i,
  output logic        valid_o,
  output logic [63:0] integer_value_o
);
  import p64u_pkg::*;

  s1_t s1;
  s2_t s2;

  assign busy = 1'b0;

  p64u_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start),
    .posit_bits_i (posit_bits_i),
    .s1_o         (s1)
  );

  p64u_align u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .s2_o   (s2)
  );

  p64u_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s2_i    (s2),
    .valid_o (valid_o),
    .value_o (integer_value_o)
  );

  `P64U_ASSERT_NEXT(a_latency, start && !busy, ##3 valid_o, "result strobe missing")
  `P64U_ASSERT_NOW(a_neg_zero, valid_o && $past(posit_bits_i[63], 4),
    integer_value_o == '0, "negative input gave nonzero result")
  `P64U_ASSERT_NOW(a_saturate, valid_o && !$past(posit_bits_i[63], 4) && $past(posit_bits_i, 4) > MAX_FIT_WORD,
    integer_value_o == ALL_ONES, "large input did not saturate")

endmodule

### test/posit64_to_unsigned_int_test.sv
// Predicts and checks posit-to-integer conversion results in transfer order.
class conversion_board;
  logic [63:0] expected_values[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Rounds a posit word (two exponent bits) to the nearest unsigned integer, ties to even.
  function logic [63:0] round_to_uint(logic [63:0] w);
    logic [63:0] u;
    logic [63:0] sig;
    logic [63:0] res;
    logic [63:0] sticky_mask;
    int unsigned scale;
    int unsigned sh;
    int unsigned i;
    bit rnd;
    bit sticky;
    scale = 0;
    if (w[63]) return 64'd0;                               // negative or NaR
    if (w <= 64'h3800_0000_0000_0000) return 64'd0;        // at most one half
    if (w < 64'h4400_0000_0000_0000) return 64'd1;
    if (w <= 64'h4A00_0000_0000_0000) return 64'd2;        // up to two and a half
    if (w > 64'h7FFF_BFFF_FFFF_FFFF) return {64{1'b1}};
    u = w - 64'h4000_0000_0000_0000;
    for (i = 0; i < 62 && u[61]; i++) begin
      scale += 4;
      u = (u - 64'h2000_0000_0000_0000) << 1;
    end
    u = u << 1;
    if (u[61]) scale += 2;
    if (u[60]) scale += 1;
    sig = (u | 64'h1000_0000_0000_0000) & 64'h1FFF_FFFF_FFFF_FFFF;
    if (scale > 63) return {64{1'b1}};
    if (scale > 60) return sig << (scale - 60);
    sh = 60 - scale;
    if (sh == 0) return sig;
    res = sig >> sh;
    rnd = sig[sh-1];
    sticky_mask = (64'd1 << (sh - 1)) - 64'd1;
    sticky = (sig & sticky_mask) != 64'd0;
    if (rnd && (res[0] || sticky)) res = res + 64'd1;
    return res;
  endfunction

  function void note_word(logic [63:0] w);
    expected_values.push_back(round_to_uint(w));
  endfunction

  function void check_value(logic [63:0] actual);
    logic [63:0] want;
    if (expected_values.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, actual);
      errors++;
    end else begin
      want = expected_values.pop_front();
      if (actual !== want) begin
        $display("%0t: integer_value mismatch, expected %h, actual %h", $time, want, actual);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_values.size();
  endfunction
endclass

module posit64_to_unsigned_int_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 580;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] posit_bits_i = 64'd0;
  logic        valid_o;
  logic [63:0] integer_value_o;

  conversion_board board = new();
  int quiet_cycles = 0;

  posit64_to_unsigned_int DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .posit_bits_i    (posit_bits_i),
    .valid_o         (valid_o),
    .integer_value_o (integer_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Values read right after the edge are the ones the DUT saw at that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_word(posit_bits_i);
      if (valid_o) board.check_value(integer_value_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Well-formed positive word: k+1 regime ones, terminator, then random exponent/fraction.
  function automatic logic [63:0] regime_word();
    int unsigned k;
    logic [63:0] ones;
    logic [63:0] low;
    k = $urandom_range(16);
    ones = ((64'd1 << (k + 1)) - 64'd1) << (62 - k);
    low = rand_word() & ((64'd1 << (61 - k)) - 64'd1);
    return ones | low;
  endfunction

  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    logic [63:0] edges[7];
    int unsigned sel;
    int unsigned j;
    int delta;
    edges = '{64'h3800_0000_0000_0000, 64'h4400_0000_0000_0000, 64'h4A00_0000_0000_0000,
              64'h7FFF_BFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h0000_0000_0000_0000};
    sel = $urandom_range(99);
    if (sel < 20) begin
      w = rand_word();
    end else if (sel < 65) begin
      w = regime_word();
    end else if (sel < 80) begin
      delta = $urandom_range(16);
      w = edges[$urandom_range(6)] + 64'(delta) - 64'd8;
    end else begin
      // lowest set bit at a random spot to hit exact halves
      j = $urandom_range(55);
      w = regime_word();
      w = (w & ~((64'd1 << j) - 64'd1)) | (64'd1 << j);
    end
    return w;
  endfunction

  task automatic send_word(logic [63:0] w, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      posit_bits_i <= rand_word();
      @(posedge clk_i);
    end
    start <= 1'b1;
    posit_bits_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] directed[$];
    int unsigned idle_pcts[3];
    directed = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hC000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h3800_0000_0000_0000,
      64'h3800_0000_0000_0001, 64'h4000_0000_0000_0000, 64'h43FF_FFFF_FFFF_FFFF,
      64'h4400_0000_0000_0000, 64'h4A00_0000_0000_0000, 64'h4A00_0000_0000_0001,
      64'h4E00_0000_0000_0000, 64'h5000_0000_0000_0000, 64'h5100_0000_0000_0000,
      64'h5100_0000_0000_0001, 64'h6000_0000_0000_0001, 64'h7FF0_0000_0000_0001,
      64'h7FFF_0000_0000_0000, 64'h7FFF_7FFF_FFFF_FFFF, 64'h7FFF_8FFF_FFFF_FFFF,
      64'h7FFF_BFFF_FFFF_FFFE, 64'h7FFF_BFFF_FFFF_FFFF, 64'h7FFF_C000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF
    };
    idle_pcts = '{0, 50, 15};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) send_word(directed[n], 0);
    foreach (idle_pcts[p]) begin
      repeat (RANDOM_PER_PHASE) send_word(pick_word(), idle_pcts[p]);
    end
    start <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
